FILE: rtl/assert_macros.svh
// Assertion helpers used by mpmc_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define MPMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed one cycle later");

`endif

FILE: rtl/mpmc_pkg.sv
// ----------------------------------------------------------------------------
// mpmc_pkg
// Shared constants, codes and state type of the multi-pattern matcher.
// ----------------------------------------------------------------------------
package mpmc_pkg;

	localparam int MAX_NODES    = 1024;
	localparam int MAX_PATTERNS = 256;
	localparam int ALPHABET     = 256;

	localparam int NODE_W   = 10;   // node index
	localparam int NUSED_W  = 11;   // node count, holds MAX_NODES itself
	localparam int SYM_W    = 8;
	localparam int ID_W     = 9;    // pattern id, 0 means none
	localparam int SEEN_W   = 8;    // index into the seen flags
	localparam int COUNT_W  = 9;
	localparam int GOTO_AW  = NODE_W + SYM_W;
	localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;

	localparam logic [1:0] CMD_PATTERN = 2'd0;
	localparam logic [1:0] CMD_BUILD   = 2'd1;
	localparam logic [1:0] CMD_TEXT    = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	localparam logic KIND_COUNT  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_P_GO,
		ST_P_GW,
		ST_P_END,
		ST_B_R0,
		ST_B_R1,
		ST_B_POP,
		ST_B_U,
		ST_B_FU,
		ST_B_E0,
		ST_B_E1,
		ST_B_H0,
		ST_B_H1,
		ST_T_GO,
		ST_T_GW,
		ST_C_RD,
		ST_C_WT,
		ST_T_END,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/mpmc_ram.sv
// ----------------------------------------------------------------------------
// mpmc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/multi_pattern_match_counter_top.sv
// ----------------------------------------------------------------------------
// multi_pattern_match_counter_top
// Aho-Corasick matcher: trie load, failure-link build and text walk that
// counts distinct patterns seen.
//
//   channel | signals                          | beat
//   --------+----------------------------------+-----------------------------
//   in      | in_valid, in_stall               | command, data_byte, last
//   out     | out_valid, out_stall             | kind, match_count, table_full
//
// A pattern byte holds in_stall high through P_GO, P_GW and P_END (only
// P_END once the pattern has overflowed), a text byte through T_GO and T_GW
// per failure hop, C_RD and C_WT per output-chain node, and T_END; a last
// byte also passes EMIT to post its result. Every step waits on a registered
// read of the goto, failure or id memory. Build scans all ALPHABET symbols
// of each node plus the failure-chain hops. After reset and a clear command
// a sweep holds in_stall high while it zeroes GOTO_DEPTH (262144) addresses.
// A finished result sits in the output register; the next beat is taken
// while it waits, and only a second result waits for it to be taken.
// ----------------------------------------------------------------------------
module multi_pattern_match_counter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [8:0] match_count,
	output logic       table_full
);

	localparam int NW = mpmc_pkg::NODE_W;
	localparam int SW = mpmc_pkg::SYM_W;
	localparam int IW = mpmc_pkg::ID_W;
	localparam int CW = mpmc_pkg::COUNT_W;
	localparam int GW = mpmc_pkg::GOTO_AW;
	localparam int SEEN_IDX_W = mpmc_pkg::SEEN_W;

	mpmc_pkg::state_t state_q, state_d;

	logic [GW-1:0]                    sweep_q, sweep_d;
	logic [mpmc_pkg::NUSED_W-1:0]     nodes_used_q, nodes_used_d;
	logic [IW-1:0]                    pl_q, pl_d;
	logic [NW-1:0]                    cur_q, cur_d;
	logic                             ovf_q, ovf_d;
	logic [SW-1:0]                    sym_q, sym_d;
	logic                             last_q, last_d;
	logic [mpmc_pkg::MAX_PATTERNS-1:0] seen_q, seen_d;
	logic [CW-1:0]                    cnt_q, cnt_d;
	logic [SW-1:0]                    s_q, s_d;
	logic [NW-1:0]                    head_q, head_d, tail_q, tail_d;
	logic [NW-1:0]                    u_q, u_d, fu_q, fu_d, c_q, c_d, h_q, h_d;
	logic                             res_kind_q, res_kind_d;
	logic [CW-1:0]                    res_count_q, res_count_d;
	logic                             res_full_q, res_full_d;
	logic                             out_valid_q, out_valid_d;
	logic                             kind_q, kind_d;
	logic [CW-1:0]                    match_count_q, match_count_d;
	logic                             table_full_q, table_full_d;

	// memory ports
	logic          goto_we, fail_we, pid_we, queue_we;
	logic [GW-1:0] goto_waddr, goto_raddr;
	logic [NW-1:0] goto_wdata, goto_rdata;
	logic [NW-1:0] fail_waddr, fail_raddr, fail_wdata, fail_rdata;
	logic [NW-1:0] pid_waddr, pid_raddr;
	logic [IW-1:0] pid_wdata, pid_rdata;
	logic [NW-1:0] queue_waddr, queue_raddr, queue_wdata, queue_rdata;

	logic [SEEN_IDX_W-1:0] seen_idx;

	mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::GOTO_DEPTH)) u_goto_ram (
		.clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
		.raddr(goto_raddr), .rdata(goto_rdata)
	);

	mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::MAX_NODES)) u_fail_ram (
		.clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
		.raddr(fail_raddr), .rdata(fail_rdata)
	);

	mpmc_ram #(.WIDTH(IW), .DEPTH(mpmc_pkg::MAX_NODES)) u_pid_ram (
		.clk(clk), .we(pid_we), .waddr(pid_waddr), .wdata(pid_wdata),
		.raddr(pid_raddr), .rdata(pid_rdata)
	);

	mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::MAX_NODES)) u_queue_ram (
		.clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
		.raddr(queue_raddr), .rdata(queue_rdata)
	);

	assign seen_idx = SEEN_IDX_W'(pid_rdata - IW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mpmc_pkg::ST_CLEAR;
			sweep_q      <= '0;
			nodes_used_q <= mpmc_pkg::NUSED_W'(1);
			pl_q         <= '0;
			cur_q        <= '0;
			ovf_q        <= 1'b0;
			seen_q       <= '0;
			cnt_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			sweep_q      <= sweep_d;
			nodes_used_q <= nodes_used_d;
			pl_q         <= pl_d;
			cur_q        <= cur_d;
			ovf_q        <= ovf_d;
			seen_q       <= seen_d;
			cnt_q        <= cnt_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		sym_q         <= sym_d;
		last_q        <= last_d;
		s_q           <= s_d;
		u_q           <= u_d;
		fu_q          <= fu_d;
		c_q           <= c_d;
		h_q           <= h_d;
		res_kind_q    <= res_kind_d;
		res_count_q   <= res_count_d;
		res_full_q    <= res_full_d;
		kind_q        <= kind_d;
		match_count_q <= match_count_d;
		table_full_q  <= table_full_d;
	end

	always_comb begin
		state_d       = state_q;
		sweep_d       = sweep_q;
		nodes_used_d  = nodes_used_q;
		pl_d          = pl_q;
		cur_d         = cur_q;
		ovf_d         = ovf_q;
		sym_d         = sym_q;
		last_d        = last_q;
		seen_d        = seen_q;
		cnt_d         = cnt_q;
		s_d           = s_q;
		head_d        = head_q;
		tail_d        = tail_q;
		u_d           = u_q;
		fu_d          = fu_q;
		c_d           = c_q;
		h_d           = h_q;
		res_kind_d    = res_kind_q;
		res_count_d   = res_count_q;
		res_full_d    = res_full_q;
		kind_d        = kind_q;
		match_count_d = match_count_q;
		table_full_d  = table_full_q;
		out_valid_d   = out_valid_q && out_stall;

		goto_we     = 1'b0;
		goto_waddr  = {cur_q, sym_q};
		goto_wdata  = '0;
		goto_raddr  = {cur_q, sym_q};
		fail_we     = 1'b0;
		fail_waddr  = c_q;
		fail_wdata  = '0;
		fail_raddr  = cur_q;
		pid_we      = 1'b0;
		pid_waddr   = cur_q;
		pid_wdata   = '0;
		pid_raddr   = h_q;
		queue_we    = 1'b0;
		queue_waddr = tail_q;
		queue_wdata = '0;
		queue_raddr = head_q;

		unique case (state_q)
			mpmc_pkg::ST_CLEAR: begin
				goto_we    = 1'b1;
				goto_waddr = sweep_q;
				fail_we    = 1'b1;
				fail_waddr = sweep_q[NW-1:0];
				pid_we     = 1'b1;
				pid_waddr  = sweep_q[NW-1:0];
				sweep_d    = sweep_q + GW'(1);
				if (sweep_q == '1) begin
					nodes_used_d = mpmc_pkg::NUSED_W'(1);
					pl_d         = '0;
					cur_d        = '0;
					ovf_d        = 1'b0;
					seen_d       = '0;
					cnt_d        = '0;
					state_d      = mpmc_pkg::ST_IDLE;
				end
			end

			mpmc_pkg::ST_IDLE: begin
				if (in_valid) begin
					sym_d  = data_byte;
					last_d = last;
					unique case (command)
						mpmc_pkg::CMD_PATTERN: begin
							state_d = ovf_q ? mpmc_pkg::ST_P_END : mpmc_pkg::ST_P_GO;
						end
						mpmc_pkg::CMD_BUILD: begin
							s_d     = '0;
							head_d  = '0;
							tail_d  = '0;
							state_d = mpmc_pkg::ST_B_R0;
						end
						mpmc_pkg::CMD_TEXT: begin
							state_d = mpmc_pkg::ST_T_GO;
						end
						default: begin
							sweep_d = '0;
							state_d = mpmc_pkg::ST_CLEAR;
						end
					endcase
				end
			end

			mpmc_pkg::ST_P_GO: begin
				goto_raddr = {cur_q, sym_q};
				state_d    = mpmc_pkg::ST_P_GW;
			end

			mpmc_pkg::ST_P_GW: begin
				if (goto_rdata != '0) begin
					cur_d = goto_rdata;
				end else if (nodes_used_q < mpmc_pkg::NUSED_W'(mpmc_pkg::MAX_NODES)) begin
					goto_we      = 1'b1;
					goto_waddr   = {cur_q, sym_q};
					goto_wdata   = nodes_used_q[NW-1:0];
					cur_d        = nodes_used_q[NW-1:0];
					nodes_used_d = nodes_used_q + mpmc_pkg::NUSED_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
				state_d = mpmc_pkg::ST_P_END;
			end

			mpmc_pkg::ST_P_END: begin
				if (!last_q) begin
					state_d = mpmc_pkg::ST_IDLE;
				end else begin
					if (!ovf_q && pl_q < IW'(mpmc_pkg::MAX_PATTERNS) && cur_q != '0) begin
						pl_d      = pl_q + IW'(1);
						pid_we    = 1'b1;
						pid_waddr = cur_q;
						pid_wdata = pl_q + IW'(1);
					end
					res_kind_d  = mpmc_pkg::KIND_STATUS;
					res_count_d = '0;
					res_full_d  = ovf_q;
					ovf_d       = 1'b0;
					cur_d       = '0;
					state_d     = mpmc_pkg::ST_EMIT;
				end
			end

			// Root children first: their failure links are the root.
			mpmc_pkg::ST_B_R0: begin
				goto_raddr = {NW'(0), s_q};
				state_d    = mpmc_pkg::ST_B_R1;
			end

			mpmc_pkg::ST_B_R1: begin
				if (goto_rdata != '0) begin
					fail_we     = 1'b1;
					fail_waddr  = goto_rdata;
					fail_wdata  = '0;
					queue_we    = 1'b1;
					queue_waddr = tail_q;
					queue_wdata = goto_rdata;
					tail_d      = tail_q + NW'(1);
				end
				if (s_q == SW'(mpmc_pkg::ALPHABET - 1)) begin
					state_d = mpmc_pkg::ST_B_POP;
				end else begin
					s_d     = s_q + SW'(1);
					state_d = mpmc_pkg::ST_B_R0;
				end
			end

			mpmc_pkg::ST_B_POP: begin
				if (head_q == tail_q) begin
					cur_d   = '0;
					state_d = mpmc_pkg::ST_IDLE;
				end else begin
					queue_raddr = head_q;
					head_d      = head_q + NW'(1);
					state_d     = mpmc_pkg::ST_B_U;
				end
			end

			mpmc_pkg::ST_B_U: begin
				u_d        = queue_rdata;
				fail_raddr = queue_rdata;
				s_d        = '0;
				state_d    = mpmc_pkg::ST_B_FU;
			end

			mpmc_pkg::ST_B_FU: begin
				fu_d    = fail_rdata;
				state_d = mpmc_pkg::ST_B_E0;
			end

			mpmc_pkg::ST_B_E0: begin
				goto_raddr = {u_q, s_q};
				state_d    = mpmc_pkg::ST_B_E1;
			end

			mpmc_pkg::ST_B_E1: begin
				if (goto_rdata != '0) begin
					c_d     = goto_rdata;
					h_d     = fu_q;
					state_d = mpmc_pkg::ST_B_H0;
				end else if (s_q == SW'(mpmc_pkg::ALPHABET - 1)) begin
					state_d = mpmc_pkg::ST_B_POP;
				end else begin
					s_d     = s_q + SW'(1);
					state_d = mpmc_pkg::ST_B_E0;
				end
			end

			mpmc_pkg::ST_B_H0: begin
				goto_raddr = {h_q, s_q};
				fail_raddr = h_q;
				state_d    = mpmc_pkg::ST_B_H1;
			end

			// Walk the failure chain until an edge on this symbol turns up
			// or the root is reached.
			mpmc_pkg::ST_B_H1: begin
				if (goto_rdata != '0 || h_q == '0) begin
					fail_we     = 1'b1;
					fail_waddr  = c_q;
					fail_wdata  = goto_rdata;
					queue_we    = 1'b1;
					queue_waddr = tail_q;
					queue_wdata = c_q;
					tail_d      = tail_q + NW'(1);
					if (s_q == SW'(mpmc_pkg::ALPHABET - 1)) begin
						state_d = mpmc_pkg::ST_B_POP;
					end else begin
						s_d     = s_q + SW'(1);
						state_d = mpmc_pkg::ST_B_E0;
					end
				end else begin
					h_d     = fail_rdata;
					state_d = mpmc_pkg::ST_B_H0;
				end
			end

			mpmc_pkg::ST_T_GO: begin
				goto_raddr = {cur_q, sym_q};
				fail_raddr = cur_q;
				state_d    = mpmc_pkg::ST_T_GW;
			end

			mpmc_pkg::ST_T_GW: begin
				if (goto_rdata == '0 && cur_q != '0) begin
					cur_d   = fail_rdata;
					state_d = mpmc_pkg::ST_T_GO;
				end else begin
					cur_d   = goto_rdata;
					h_d     = goto_rdata;
					state_d = mpmc_pkg::ST_C_RD;
				end
			end

			mpmc_pkg::ST_C_RD: begin
				if (h_q == '0) begin
					state_d = mpmc_pkg::ST_T_END;
				end else begin
					pid_raddr  = h_q;
					fail_raddr = h_q;
					state_d    = mpmc_pkg::ST_C_WT;
				end
			end

			// The distinct count grows only when a flag goes from clear to set.
			mpmc_pkg::ST_C_WT: begin
				if (pid_rdata != '0 && !seen_q[seen_idx]) begin
					seen_d[seen_idx] = 1'b1;
					cnt_d            = cnt_q + CW'(1);
				end
				h_d     = fail_rdata;
				state_d = mpmc_pkg::ST_C_RD;
			end

			mpmc_pkg::ST_T_END: begin
				if (!last_q) begin
					state_d = mpmc_pkg::ST_IDLE;
				end else begin
					res_kind_d  = mpmc_pkg::KIND_COUNT;
					res_count_d = cnt_q;
					res_full_d  = 1'b0;
					seen_d      = '0;
					cnt_d       = '0;
					cur_d       = '0;
					state_d     = mpmc_pkg::ST_EMIT;
				end
			end

			mpmc_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d   = 1'b1;
					kind_d        = res_kind_q;
					match_count_d = res_count_q;
					table_full_d  = res_full_q;
					state_d       = mpmc_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = mpmc_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall    = (state_q != mpmc_pkg::ST_IDLE);
	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign match_count = match_count_q;
	assign table_full  = table_full_q;

endmodule

FILE: rtl/mpmc_checker.sv
// ----------------------------------------------------------------------------
// mpmc_checker
// Port-level checks on the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] command,
	input logic [7:0] data_byte,
	input logic       last,
	input logic       out_valid,
	input logic       out_stall,
	input logic       kind,
	input logic [8:0] match_count,
	input logic       table_full
);

	// A held result stays on the port unchanged.
	`MPMC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(match_count) && $stable(kind) && $stable(table_full))

	// Every accepted beat keeps the block busy in the following cycle.
	`MPMC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A load status never carries a count.
	`MPMC_ASSERT_NOW(a_status_no_count, clk, arst_n, out_valid && kind, match_count == 9'd0)

	// A count result never flags an overflow, nor exceeds the pattern limit.
	`MPMC_ASSERT_NOW(a_count_clean, clk, arst_n, out_valid && !kind, !table_full && match_count <= 9'd256)

endmodule

bind multi_pattern_match_counter_top mpmc_checker u_mpmc_checker (.*);
